// ----- rtl/ipow_pkg.sv -----
// Package for the integer power unit: exponent width, data width, and the
// command and status structs passed between the controller and the datapath.
// No dependencies.
package ipow_pkg;

    localparam int EXP_BITS = 31;
    localparam int DATA_W   = 64;
    localparam int HALF_W   = DATA_W / 2;
    localparam int EXP_IN_W = 31;

    typedef logic [DATA_W-1:0]   data_t;
    typedef logic [HALF_W-1:0]   half_t;
    typedef logic [EXP_BITS-1:0] exp_t;

    typedef struct packed {
        logic load;   // take a new base and exponent, start the result at one
        logic mult;   // form the 32-bit partial products into registers
        logic step;   // sum the partials, update result and base, shift exponent
        logic store;  // copy the finished result into the output register
    } ipow_cmd_t;

    typedef struct packed {
        logic exp_zero;  // no set exponent bits remain
    } ipow_status_t;

endpackage

// ----- rtl/ipow_dp.sv -----
// Datapath of the integer power unit: base, result and exponent registers,
// 32-bit partial product multipliers and the output register.
// Depends on ipow_pkg.
module ipow_dp (
    input  logic                     clk,
    input  logic signed [63:0]       base_value,
    input  logic        [30:0]       exponent,
    input  ipow_pkg::ipow_cmd_t      cmd,
    output ipow_pkg::ipow_status_t   status,
    output logic signed [63:0]       power
);
    import ipow_pkg::*;

    data_t base_reg;
    data_t acc_reg;
    exp_t  exp_reg;
    data_t out_reg;

    // Partial products of acc * base and base * base, low 64 bits only.
    data_t pp_acc_ll_reg;
    half_t pp_acc_lh_reg;
    half_t pp_acc_hl_reg;
    data_t pp_sq_ll_reg;
    half_t pp_sq_lh_reg;

    half_t base_lo;
    half_t base_hi;
    half_t acc_lo;
    half_t acc_hi;
    data_t acc_ll_next;
    half_t acc_lh_next;
    half_t acc_hl_next;
    data_t sq_ll_next;
    half_t sq_lh_next;
    half_t acc_cross;
    half_t sq_cross;
    data_t acc_sum;
    data_t sq_sum;

    assign base_lo = base_reg[HALF_W-1:0];
    assign base_hi = base_reg[DATA_W-1:HALF_W];
    assign acc_lo  = acc_reg[HALF_W-1:0];
    assign acc_hi  = acc_reg[DATA_W-1:HALF_W];

    assign acc_ll_next = data_t'(acc_lo) * data_t'(base_lo);
    assign acc_lh_next = acc_lo * base_hi;
    assign acc_hl_next = acc_hi * base_lo;
    assign sq_ll_next  = data_t'(base_lo) * data_t'(base_lo);
    assign sq_lh_next  = base_lo * base_hi;

    // The two cross terms of the square are equal, so one is doubled.
    assign acc_cross = pp_acc_lh_reg + pp_acc_hl_reg;
    assign sq_cross  = {pp_sq_lh_reg[HALF_W-2:0], 1'b0};
    assign acc_sum   = pp_acc_ll_reg + {acc_cross, half_t'(0)};
    assign sq_sum    = pp_sq_ll_reg + {sq_cross, half_t'(0)};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= data_t'($unsigned(base_value));
            acc_reg  <= data_t'(1);
            exp_reg  <= exp_t'(exponent);
        end
        else if (cmd.step)
        begin
            if (exp_reg[0])
            begin
                acc_reg <= acc_sum;
            end
            base_reg <= sq_sum;
            exp_reg  <= exp_reg >> 1;
        end

        if (cmd.mult)
        begin
            pp_acc_ll_reg <= acc_ll_next;
            pp_acc_lh_reg <= acc_lh_next;
            pp_acc_hl_reg <= acc_hl_next;
            pp_sq_ll_reg  <= sq_ll_next;
            pp_sq_lh_reg  <= sq_lh_next;
        end

        if (cmd.store)
        begin
            out_reg <= acc_reg;
        end
    end

    assign status.exp_zero = (exp_reg == '0);
    assign power           = $signed(out_reg);

endmodule

// ----- rtl/ipow_ctrl.sv -----
// Controller of the integer power unit: sequences load, multiply and update
// steps and owns the input stall and the output valid register.
// Depends on ipow_pkg.
module ipow_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  logic                     out_stall,
    input  ipow_pkg::ipow_status_t   status,
    output ipow_pkg::ipow_cmd_t      cmd
);
    import ipow_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MULT = 2'd1;
    localparam logic [1:0] S_STEP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // The output register can take a new result when it is empty or being drained.
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MULT;
                end
            end
            S_MULT:
            begin
                if (status.exp_zero)
                begin
                    if (slot_free)
                    begin
                        cmd.store  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.mult   = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_MULT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.store)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/integer_power_by_squaring_unit.sv -----
// Integer power unit top level: base to a non-negative exponent, 64-bit wrapping.
// Depends on ipow_pkg, ipow_ctrl and ipow_dp.
//
// One beat in carries a signed 64-bit base and a 31-bit exponent; one beat out
// carries the power, wrapped modulo 2^64 with no overflow flag, and an exponent
// of zero gives one. The exponent is scanned from its low end up to its highest
// set bit: in the MULT state the 32-bit partial products of the
// result-times-base and base-squared multiplies are formed into registers,
// and in the STEP state that follows they are summed. The result is stored once
// no set exponent bits remain and the output register is free. One item is
// worked on at a time; the next is accepted the cycle after the result enters
// the output register, which holds it while the downstream side stalls.
module integer_power_by_squaring_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [63:0] base_value,
    input  logic        [30:0] exponent,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] power
);
    import ipow_pkg::*;

    ipow_cmd_t    cmd;
    ipow_status_t status;

    ipow_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ipow_dp u_dp (
        .clk        (clk),
        .base_value (base_value),
        .exponent   (exponent),
        .cmd        (cmd),
        .status     (status),
        .power      (power)
    );

    // An accepted beat always starts work, so the input stalls on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an accepted beat");

    // Every update step follows a partial product capture.
    a_step_after_mult: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> $past(cmd.mult))
        else $error("update step without captured partial products");

    // A result is stored only once all exponent bits are consumed.
    a_store_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> status.exp_zero && !(out_valid && out_stall))
        else $error("result stored early or over a held result");

    // While idle the datapath neither multiplies nor updates.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !cmd.mult && !cmd.step && !cmd.store)
        else $error("datapath active while idle");

endmodule
